/* rtl/btc_pkg.sv */
`timescale 1ns / 1ps
package btc_pkg;

   localparam int DUTY_W   = 7;
   localparam int SAMPLE_W = 12;
   localparam int HALL_W   = 3;
   localparam int LEVEL_W  = 11;

   localparam logic [LEVEL_W-1:0] ADC_LOW   = 11'd496;
   localparam logic [LEVEL_W-1:0] ADC_HIGH  = 11'd1539;
   localparam logic [DUTY_W-1:0]  FULL_DUTY = 7'd100;

   // percent = (level - low) * 100 / 1043, done as one multiply by a reciprocal
   localparam int PCT_SHIFT = 21;
   localparam int PROD_W    = 29;
   localparam logic [PROD_W-1:0] PCT_RECIP = 29'd201070;

   localparam logic [DUTY_W-1:0] FLOOR_RESET   = 7'd10;
   localparam logic [DUTY_W-1:0] CEILING_RESET = 7'd90;

   localparam int CSR_INDEX_W_DEFAULT = 4;
   localparam int CSR_FLOOR   = 0;
   localparam int CSR_CEILING = 1;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_HALL   = 1'b1;

   typedef struct packed {
      logic                op;
      logic [SAMPLE_W-1:0] adc_sample;
      logic [HALL_W-1:0]   hall_code;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_a;
      logic [DUTY_W-1:0] duty_b;
      logic [DUTY_W-1:0] duty_c;
      logic [DUTY_W-1:0] throttle_now;
   } rsp_type;

   typedef struct packed {
      logic [DUTY_W-1:0] floor_pct;
      logic [DUTY_W-1:0] ceiling_pct;
   } limits_type;

endpackage

/* rtl/btc_csr.sv */
`timescale 1ns / 1ps
module btc_csr
   import btc_pkg::*;
#(
   parameter int CSR_INDEX_W = CSR_INDEX_W_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DUTY_W-1:0]      csr_wdata,
   output limits_type             limits
);

   limits_type limits_ff, limits_in;

   assign csr_ready = 1'b1;
   assign limits    = limits_ff;

   always_comb begin
      limits_in = limits_ff;
      if (csr_valid) begin
         // indexes past the register list are dropped
         if (csr_index == CSR_INDEX_W'(CSR_FLOOR)) begin
            limits_in.floor_pct = csr_wdata;
         end else if (csr_index == CSR_INDEX_W'(CSR_CEILING)) begin
            limits_in.ceiling_pct = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.floor_pct   <= FLOOR_RESET;
         limits_ff.ceiling_pct <= CEILING_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

endmodule

/* rtl/btc_core.sv */
`timescale 1ns / 1ps
module btc_core
   import btc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,
   input  req_type    item,
   input  limits_type limits,
   output rsp_type    result
);

   localparam logic [HALL_W-1:0] HALL_A   = 3'd1;
   localparam logic [HALL_W-1:0] HALL_AB  = 3'd3;
   localparam logic [HALL_W-1:0] HALL_B   = 3'd2;
   localparam logic [HALL_W-1:0] HALL_BC  = 3'd6;
   localparam logic [HALL_W-1:0] HALL_C   = 3'd4;
   localparam logic [HALL_W-1:0] HALL_AC  = 3'd5;

   logic [LEVEL_W-1:0] filt_ff, filt_in;
   logic [DUTY_W-1:0]  level_ff, level_in;
   logic [DUTY_W-1:0]  duty_a_ff, duty_a_in;
   logic [DUTY_W-1:0]  duty_b_ff, duty_b_in;
   logic [DUTY_W-1:0]  duty_c_ff, duty_c_in;

   logic [LEVEL_W-1:0] clamped;
   logic [LEVEL_W-1:0] filt_new;
   logic [LEVEL_W-1:0] offset;
   logic [PROD_W-1:0]  prod;
   logic [DUTY_W-1:0]  pct;
   logic [DUTY_W-1:0]  level_new;
   logic [2:0]         drive_sel;
   logic               hall_ok;

   always_comb begin
      if (item.adc_sample < SAMPLE_W'(ADC_LOW)) begin
         clamped = ADC_LOW;
      end else if (item.adc_sample > SAMPLE_W'(ADC_HIGH)) begin
         clamped = ADC_HIGH;
      end else begin
         clamped = item.adc_sample[LEVEL_W-1:0];
      end

      // half step toward the sample, truncated toward the old level
      if (clamped >= filt_ff) begin
         filt_new = filt_ff + ((clamped - filt_ff) >> 1);
      end else begin
         filt_new = filt_ff - ((filt_ff - clamped) >> 1);
      end

      offset = filt_new - ADC_LOW;
      prod   = PROD_W'(offset) * PCT_RECIP;
      pct    = prod[PCT_SHIFT +: DUTY_W];

      if (pct < limits.floor_pct) begin
         level_new = '0;
      end else if (pct > limits.ceiling_pct) begin
         level_new = limits.ceiling_pct;
      end else begin
         level_new = pct;
      end
   end

   // one bit per phase a,b,c: set drives the throttle, clear holds full duty
   always_comb begin
      hall_ok = 1'b1;
      case (item.hall_code)
         HALL_AC: drive_sel = 3'b101;
         HALL_A:  drive_sel = 3'b100;
         HALL_AB: drive_sel = 3'b110;
         HALL_B:  drive_sel = 3'b010;
         HALL_BC: drive_sel = 3'b011;
         HALL_C:  drive_sel = 3'b001;
         default: begin
            drive_sel = 3'b000;
            hall_ok   = 1'b0;
         end
      endcase
   end

   always_comb begin
      filt_in   = filt_ff;
      level_in  = level_ff;
      duty_a_in = duty_a_ff;
      duty_b_in = duty_b_ff;
      duty_c_in = duty_c_ff;
      if (item.op == OP_SAMPLE) begin
         filt_in  = filt_new;
         level_in = level_new;
      end else if (hall_ok) begin
         duty_a_in = drive_sel[2] ? level_ff : FULL_DUTY;
         duty_b_in = drive_sel[1] ? level_ff : FULL_DUTY;
         duty_c_in = drive_sel[0] ? level_ff : FULL_DUTY;
      end
   end

   assign result.duty_a       = duty_a_in;
   assign result.duty_b       = duty_b_in;
   assign result.duty_c       = duty_c_in;
   assign result.throttle_now = level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff   <= ADC_LOW;
         level_ff  <= '0;
         duty_a_ff <= '0;
         duty_b_ff <= '0;
         duty_c_ff <= '0;
      end else if (enable) begin
         filt_ff   <= filt_in;
         level_ff  <= level_in;
         duty_a_ff <= duty_a_in;
         duty_b_ff <= duty_b_in;
         duty_c_ff <= duty_c_in;
      end
   end

endmodule

/* rtl/bldc_throttle_commutation.sv */
`timescale 1ns / 1ps
// Throttle filter and six-step hall commutation.
// req_ carries one item: op 0 is a throttle converter sample, op 1 a hall
// change. An item is taken at a clock edge with req_valid high and req_stall
// low. Every item gives exactly one rsp_ item with the three phase duties
// and the limited throttle percent as they stand after that item.
// An item taken into the input register has its result in the output register
// once it advances. Throughput: one item per cycle while rsp_stall is low;
// the input register feeds a single pass of clamp, averaging, one reciprocal
// multiply and the hall pattern pick.
// While rsp_stall is high the result holds; one more item may wait in the
// input register, then req_stall rises until the result is taken.
// csr_ writes the floor (index 0) and ceiling (index 1) percents; csr_ready
// is always high and writes belong to idle periods.
// Synchronous reset empties both registers, sets the filter to its low
// end, throttle and duties to 0, floor to 10 and ceiling to 90.
module bldc_throttle_commutation
   import btc_pkg::*;
#(
   parameter int CSR_INDEX_W = CSR_INDEX_W_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DUTY_W-1:0]      csr_wdata
);

   logic       req_valid_ff, req_valid_in;
   req_type    req_data_ff, req_data_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       advance;
   limits_type limits;
   rsp_type    result;

   btc_csr #(
      .CSR_INDEX_W(CSR_INDEX_W)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   btc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .item   (req_data_ff),
      .limits (limits),
      .result (result)
   );

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_data_in  = req_data_ff;
      if (!req_stall) begin
         req_valid_in = req_valid;
         req_data_in  = req_data;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
